@@ rtl/dss_pkg.sv @@
// dss_pkg: shared widths and the seven-segment lookup for the decimal serializer.
// No dependencies.
package dss_pkg;

	localparam int VALUE_W   = 16;
	localparam int DIGITS    = 4;
	localparam int DIGIT_W   = 4;
	localparam int SEG_W     = 8;
	localparam int BCD_W     = DIGITS * DIGIT_W;
	localparam int WORD_W    = DIGITS * SEG_W;
	localparam int BIT_IDX_W = $clog2(WORD_W);
	localparam int CNT_W     = $clog2(VALUE_W);

	typedef logic [WORD_W-1:0] seg_word_t;

	function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] d);
		logic [SEG_W-1:0] s;
		unique case (d)
			4'd0: s = 8'hee;
			4'd1: s = 8'h60;
			4'd2: s = 8'hcd;
			4'd3: s = 8'he9;
			4'd4: s = 8'h63;
			4'd5: s = 8'hab;
			4'd6: s = 8'haf;
			4'd7: s = 8'he0;
			4'd8: s = 8'hef;
			4'd9: s = 8'heb;
			default: s = '0;
		endcase
		return s;
	endfunction

endpackage

@@ rtl/decimal_seven_segment_serializer.sv @@
// Decimal seven-segment serializer: a 16-bit number in, 32 segment bits out,
// thousands digit first (taken modulo 10), each byte MSB first, leading zeros
// blanked, last_bit high on the 32nd bit. The front converts a number to BCD,
// pushes it into the queue and can accept the next number while the back
// is still shifting; the back sends one bit per cycle unless bit_stall holds it,
// with no gap between numbers while the queue holds one, so the sustained
// rate is set by the output shifter.
// Depends on dss_pkg, dss_front, dss_queue, dss_back.
module decimal_seven_segment_serializer import dss_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [VALUE_W-1:0] value,
	input  logic               value_valid,
	output logic               value_stall,
	output logic               serial_bit,
	output logic [1:0]         digit_slot,
	output logic               last_bit,
	output logic               bit_valid,
	input  logic               bit_stall
);

	logic      q_push;
	logic      q_full;
	logic      q_pop;
	logic      q_not_empty;
	seg_word_t q_wr_word;
	seg_word_t q_rd_word;

	dss_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.value       (value),
		.value_valid (value_valid),
		.value_stall (value_stall),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_word      (q_wr_word)
	);

	dss_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wr_word   (q_wr_word),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.rd_word   (q_rd_word)
	);

	dss_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_word      (q_rd_word),
		.q_pop       (q_pop),
		.serial_bit  (serial_bit),
		.digit_slot  (digit_slot),
		.last_bit    (last_bit),
		.bit_valid   (bit_valid),
		.bit_stall   (bit_stall)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full))
		else $error("push into full queue");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(value_valid && !value_stall) |=> value_stall)
		else $error("front idle right after accepting");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(bit_valid && !bit_stall && !last_bit) |=> bit_valid)
		else $error("bit run broken before last bit");

	a_last_in_units: assert property (@(posedge clk) disable iff (!arst_n)
		(bit_valid && last_bit) |-> (digit_slot == 2'd3))
		else $error("last bit outside units digit");

endmodule

@@ rtl/dss_front.sv @@
// dss_front: accepts a number, converts it to four BCD digits by shift-and-add-3,
// then builds the blanked 32-bit segment word and pushes it into the queue. Uses dss_pkg.
module dss_front import dss_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [VALUE_W-1:0] value,
	input  logic               value_valid,
	output logic               value_stall,
	input  logic               q_full,
	output logic               q_push,
	output seg_word_t          q_word
);

	typedef enum logic [1:0] {IDLE, CONV, PUSH} state_t;

	state_t             state_q;
	logic [VALUE_W-1:0] bin_q;
	logic [BCD_W-1:0]   bcd_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [BCD_W-1:0]   bcd_adj;

	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd_q[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5))
				bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
			else
				bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W];
		end
	end

	// leading-zero blanking, thousands first
	always_comb begin
		logic                 seen;
		logic [DIGIT_W-1:0]   d;
		seen = 1'b0;
		for (int i = 0; i < DIGITS; i++) begin
			d = bcd_q[BCD_W-1-i*DIGIT_W -: DIGIT_W];
			if (d != '0)
				seen = 1'b1;
			q_word[WORD_W-1-i*SEG_W -: SEG_W] = seen ? seg_of(d) : '0;
		end
	end

	assign value_stall = (state_q != IDLE);
	assign q_push      = (state_q == PUSH) && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (value_valid) begin
						cnt_q   <= '0;
						state_q <= CONV;
					end
				end
				CONV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(VALUE_W-1))
						state_q <= PUSH;
				end
				PUSH: begin
					if (!q_full)
						state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == IDLE && value_valid) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (state_q == CONV) begin
			bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[VALUE_W-1]};
			bin_q <= {bin_q[VALUE_W-2:0], 1'b0};
		end
	end

endmodule

@@ rtl/dss_queue.sv @@
// dss_queue: small FIFO of segment words between front and back.
// Uses dss_pkg.
module dss_queue import dss_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  seg_word_t wr_word,
	output logic      full,
	input  logic      pop,
	output logic      not_empty,
	output seg_word_t rd_word
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	seg_word_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_word   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_word;
	end

endmodule

@@ rtl/dss_back.sv @@
// dss_back: shifts each queued segment word out MSB first, one bit at a time, advancing when bit_stall is low.
// Uses dss_pkg.
module dss_back import dss_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_not_empty,
	input  seg_word_t q_word,
	output logic      q_pop,
	output logic      serial_bit,
	output logic [1:0] digit_slot,
	output logic      last_bit,
	output logic      bit_valid,
	input  logic      bit_stall
);

	seg_word_t              sr_q;
	logic [BIT_IDX_W-1:0]   idx_q;
	logic                   active_q;
	logic                   is_last;
	logic                   taken;
	logic                   load;

	assign is_last = (idx_q == BIT_IDX_W'(WORD_W-1));
	assign taken   = active_q && !bit_stall;
	assign load    = q_not_empty && (!active_q || (taken && is_last));
	assign q_pop   = load;

	assign bit_valid  = active_q;
	assign serial_bit = sr_q[WORD_W-1];
	assign digit_slot = idx_q[BIT_IDX_W-1 -: 2];
	assign last_bit   = is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
		end else begin
			if (load) begin
				active_q <= 1'b1;
				idx_q    <= '0;
			end else if (taken) begin
				if (is_last)
					active_q <= 1'b0;
				idx_q <= idx_q + BIT_IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			sr_q <= q_word;
		else if (taken)
			sr_q <= {sr_q[WORD_W-2:0], 1'b0};
	end

endmodule

@@ bench/dss_checker.sv @@
`timescale 1ns / 100ps
// dss_checker: watches the number and segment-bit channels of the decimal
// serializer, predicts the 32 bits of every accepted number and compares them in order.
// Depends on dss_pkg.
module dss_checker import dss_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [VALUE_W-1:0] value,
	input  logic               value_valid,
	input  logic               value_stall,
	input  logic               serial_bit,
	input  logic [1:0]         digit_slot,
	input  logic               last_bit,
	input  logic               bit_valid,
	input  logic               bit_stall,
	output int                 fail_count,
	output int                 backlog
);

	typedef struct packed {
		logic       seg_bit;
		logic [1:0] slot;
		logic       last;
	} seg_bit_t;

	localparam logic [7:0] SEGMENT_ROM [10] = '{
		8'hee, 8'h60, 8'hcd, 8'he9, 8'h63, 8'hab, 8'haf, 8'he0, 8'hef, 8'heb
	};

	seg_bit_t    expected_bits [$];
	seg_bit_t    want;
	int unsigned bits_seen;

	initial begin
		fail_count = 0;
		backlog    = 0;
		bits_seen  = 0;
	end

	task automatic queue_segment_bits(input logic [VALUE_W-1:0] v);
		int unsigned n;
		int unsigned digit [4];
		logic        lit;
		logic [7:0]  pattern;
		seg_bit_t    b;
		n        = v;
		digit[0] = (n / 1000) % 10;
		digit[1] = (n / 100) % 10;
		digit[2] = (n / 10) % 10;
		digit[3] = n % 10;
		lit      = 1'b0;
		for (int s = 0; s < 4; s++) begin
			if (digit[s] != 0) begin
				lit = 1'b1;
			end
			// leading zeros stay blank
			pattern = lit ? SEGMENT_ROM[digit[s]] : 8'h00;
			for (int i = 7; i >= 0; i--) begin
				b.seg_bit = pattern[i];
				b.slot    = 2'(s);
				b.last    = (s == 3) && (i == 0);
				expected_bits.push_back(b);
			end
		end
	endtask

	task automatic report_mismatch(input string msg);
		fail_count++;
		$display("[%0t] bit %0d mismatch: %s", $time, bits_seen, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_bits.delete();
			backlog <= 0;
		end else begin
			if (value_valid && !value_stall) begin
				queue_segment_bits(value);
			end
			if (bit_valid && !bit_stall) begin
				if (expected_bits.size() == 0) begin
					report_mismatch($sformatf("unexpected word bit=%0b slot=%0d last=%0b",
						serial_bit, digit_slot, last_bit));
				end else begin
					want = expected_bits.pop_front();
					if (serial_bit !== want.seg_bit) begin
						report_mismatch($sformatf("serial_bit %0b, want %0b",
							serial_bit, want.seg_bit));
					end
					if (digit_slot !== want.slot) begin
						report_mismatch($sformatf("digit_slot %0d, want %0d",
							digit_slot, want.slot));
					end
					if (last_bit !== want.last) begin
						report_mismatch($sformatf("last_bit %0b, want %0b",
							last_bit, want.last));
					end
				end
				bits_seen++;
			end
			backlog <= expected_bits.size();
		end
	end

endmodule

@@ bench/tb_decimal_seven_segment_serializer.sv @@
`timescale 1ns / 100ps
// tb_decimal_seven_segment_serializer: drives numbers into the decimal serializer with random
// gaps and output stalls, and gives the verdict. Depends on dss_pkg, dss_checker, decimal_seven_segment_serializer.
module tb_decimal_seven_segment_serializer;
	import dss_pkg::*;

	localparam int QUIET_LIMIT  = 2000;
	localparam int RANDOM_ITEMS = 360;
	localparam int TAIL_CYCLES  = 40;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic [VALUE_W-1:0] value       = '0;
	logic               value_valid = 1'b0;
	logic               value_stall;
	logic               serial_bit;
	logic [1:0]         digit_slot;
	logic               last_bit;
	logic               bit_valid;
	logic               bit_stall   = 1'b0;

	int fail_count;
	int backlog;
	int quiet_cycles = 0;
	bit idle_on      = 1'b1;

	decimal_seven_segment_serializer i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.value       (value),
		.value_valid (value_valid),
		.value_stall (value_stall),
		.serial_bit  (serial_bit),
		.digit_slot  (digit_slot),
		.last_bit    (last_bit),
		.bit_valid   (bit_valid),
		.bit_stall   (bit_stall)
	);

	dss_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.value       (value),
		.value_valid (value_valid),
		.value_stall (value_stall),
		.serial_bit  (serial_bit),
		.digit_slot  (digit_slot),
		.last_bit    (last_bit),
		.bit_valid   (bit_valid),
		.bit_stall   (bit_stall),
		.fail_count  (fail_count),
		.backlog     (backlog)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		bit_stall <= idle_on && ($urandom_range(0, 99) < 9);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((value_valid && !value_stall) || (bit_valid && !bit_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb_decimal_seven_segment_serializer failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic send_number(input logic [VALUE_W-1:0] v);
		while (idle_on && ($urandom_range(0, 99) < 9)) begin
			value_valid <= 1'b0;
			@(posedge clk);
		end
		value       <= v;
		value_valid <= 1'b1;
		@(posedge clk);
		while (value_stall) begin
			@(posedge clk);
		end
	endtask

	function automatic logic [VALUE_W-1:0] random_number();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			return VALUE_W'($urandom);
		end else if (pick < 70) begin
			return VALUE_W'($urandom_range(0, 9999));
		end else if (pick < 85) begin
			return VALUE_W'($urandom_range(0, 99));
		end
		// wrapped thousands with small remainders
		return VALUE_W'($urandom_range(0, 6) * 10000 + $urandom_range(0, 999));
	endfunction

	initial begin
		logic [VALUE_W-1:0] directed [$];
		directed = '{16'd0, 16'd1, 16'd9, 16'd10, 16'd99, 16'd100, 16'd500, 16'd999,
			16'd1000, 16'd1001, 16'd4321, 16'd7080, 16'd9999, 16'd10000, 16'd10005,
			16'd12345, 16'd20000, 16'd60000, 16'd65535, 16'h8000, 16'h5555, 16'haaaa,
			16'd8642};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i]) begin
			send_number(directed[i]);
		end
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			idle_on = !(n >= 120 && n < 220);
			send_number(random_number());
		end
		value_valid <= 1'b0;
		idle_on = 1'b1;
		@(posedge clk);
		while (backlog != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb_decimal_seven_segment_serializer passed");
		end else begin
			$display("tb_decimal_seven_segment_serializer failed");
		end
		$finish;
	end

endmodule
